// ===== hdl/nbis_pkg.sv =====
// ----------------------------------------------------------------------------
// Nearest bin index search package
// Shared widths, codes, sequencer states and the compare unit result type.
// ----------------------------------------------------------------------------
`default_nettype none

package nbis_pkg;

   // Field widths of the transactions and the configuration register.
   localparam int OP_W    = 1;
   localparam int IDX_W   = 9;
   localparam int FREQ_W  = 24;
   localparam int COUNT_W = 10;

   // Bin count after reset.
   localparam logic [COUNT_W-1:0] COUNT_RESET = 10'd512;

   // Error codes of a result.
   localparam logic ERR_NONE  = 1'b0;
   localparam logic ERR_ORDER = 1'b1;

   // Request operations.
   typedef enum logic [OP_W-1:0] {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   // Query sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_TAIL0,
      S_TAIL1,
      S_HEAD0,
      S_HEAD1,
      S_SCAN,
      S_DONE
   } state_type;

   // Result of one pass through the shared compare unit.
   typedef struct packed {
      logic [FREQ_W-1:0] diff;      // |center - entry|
      logic              closer;    // entry is strictly closer than the best so far
      logic              not_above; // entry <= previous entry
   } cmp_result_type;

endpackage

`default_nettype wire

// ===== hdl/nbis_intf.sv =====
// ----------------------------------------------------------------------------
// Nearest bin index search channel interfaces
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface nbis_req_if;
   logic                       valid;
   logic                       ready;
   logic [nbis_pkg::OP_W-1:0]  op;
   logic [nbis_pkg::IDX_W-1:0] entry_index;
   logic [nbis_pkg::FREQ_W-1:0] frequency;

   modport source (output valid, output op, output entry_index, output frequency,
                   input ready);
   modport sink   (input valid, input op, input entry_index, input frequency,
                   output ready);
endinterface

interface nbis_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [nbis_pkg::IDX_W-1:0] center_index;
   logic                       error;

   modport source (output valid, output center_index, output error, input ready);
   modport sink   (input valid, input center_index, input error, output ready);
endinterface

`default_nettype wire

// ===== hdl/nearest_bin_index_search.sv =====
// ----------------------------------------------------------------------------
// Nearest bin index search
// Bin frequency table with a linear nearest-bin scan for query transactions.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Carries
//   req      in         op, entry_index, frequency (table write or query)
//   rsp      out        center_index, error (one per query)
//   csr      in         freq_count (write only)
//
// A query reads both table ends and then scans up from bin 0 to the returned
// index, over at most freq_count bins with freq_count capped at the
// table depth; the single table read port delivers one entry per cycle to the
// shared compare unit.
// Reset clears the sequencer, the response valid and sets freq_count to 512;
// the table itself is not cleared and must be written before it is queried.
// A waiting response does not stop table writes; a query finishes its scan
// and holds in its final state until the response register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_bin_index_search #(
   parameter int MAX_BINS = 512
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   nbis_req_if.sink                          req,
   nbis_rsp_if.source                        rsp,
   input  wire logic                         csr_write_enable,
   input  wire logic [nbis_pkg::COUNT_W-1:0] csr_write_data
);
   import nbis_pkg::*;

   localparam int AW = $clog2(MAX_BINS);

   logic [COUNT_W-1:0] freq_count_ff;
   logic               idle;
   logic               req_accept;
   logic               query_start;
   logic               table_wr_en;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [FREQ_W-1:0]  rd_data;

   // Bin count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         freq_count_ff <= COUNT_RESET;
      end else if (csr_write_enable) begin
         freq_count_ff <= csr_write_data;
      end
   end

   // Request decode.
   assign req.ready   = idle;
   assign req_accept  = req.valid && idle;
   assign query_start = req_accept && (req.op == OP_QUERY);
   assign table_wr_en = req_accept && (req.op == OP_WRITE)
                        && (int'(req.entry_index) < MAX_BINS);

   nbis_table #(
      .DEPTH (MAX_BINS),
      .WIDTH (FREQ_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (table_wr_en),
      .wr_addr (AW'(req.entry_index)),
      .wr_data (req.frequency),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nbis_seq #(
      .MAX_BINS (MAX_BINS)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .query_start      (query_start),
      .query_freq       (req.frequency),
      .freq_count       (freq_count_ff),
      .idle             (idle),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data),
      .rsp_valid        (rsp.valid),
      .rsp_ready        (rsp.ready),
      .rsp_center_index (rsp.center_index),
      .rsp_error        (rsp.error)
   );

endmodule

`default_nettype wire

// ===== hdl/nbis_table.sv =====
// ----------------------------------------------------------------------------
// Nearest bin index search frequency table
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nbis_table #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 24
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with output register.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/nbis_cmp_unit.sv =====
// ----------------------------------------------------------------------------
// Nearest bin index search compare unit
// Absolute difference and the two compares shared by every scan step.
// ----------------------------------------------------------------------------
`default_nettype none

module nbis_cmp_unit (
   input  wire logic [nbis_pkg::FREQ_W-1:0] center_freq,
   input  wire logic [nbis_pkg::FREQ_W-1:0] entry,
   input  wire logic [nbis_pkg::FREQ_W-1:0] best_diff,
   input  wire logic [nbis_pkg::FREQ_W-1:0] prev_entry,
   output nbis_pkg::cmp_result_type         result
);
   import nbis_pkg::*;

   logic [FREQ_W-1:0] diff;

   // Distance from the center frequency to the table entry.
   always_comb begin
      if (center_freq > entry) begin
         diff = center_freq - entry;
      end else begin
         diff = entry - center_freq;
      end
   end

   assign result.diff      = diff;
   assign result.closer    = (best_diff > diff);
   assign result.not_above = (entry <= prev_entry);

endmodule

`default_nettype wire

// ===== hdl/nbis_seq.sv =====
// ----------------------------------------------------------------------------
// Nearest bin index search sequencer
// Steps one query through the table ends check and the linear scan.
// ----------------------------------------------------------------------------
`default_nettype none

module nbis_seq #(
   parameter int MAX_BINS = 512
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          query_start,
   input  wire logic [nbis_pkg::FREQ_W-1:0]   query_freq,
   input  wire logic [nbis_pkg::COUNT_W-1:0]  freq_count,
   output logic                               idle,
   output logic                               rd_en,
   output logic      [$clog2(MAX_BINS)-1:0]   rd_addr,
   input  wire logic [nbis_pkg::FREQ_W-1:0]   rd_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [nbis_pkg::IDX_W-1:0]    rsp_center_index,
   output logic                               rsp_error
);
   import nbis_pkg::*;

   localparam int AW   = $clog2(MAX_BINS);
   localparam int NW   = $clog2(MAX_BINS + 1);
   localparam int CNTW = (NW > COUNT_W) ? NW : COUNT_W;

   state_type         state_ff, state_in;
   logic [FREQ_W-1:0] freq_ff;
   logic [AW-1:0]     last_ff;
   logic [AW-1:0]     pos_ff;
   logic [FREQ_W-1:0] best_ff;
   logic [FREQ_W-1:0] prev_ff;
   logic              err_ff;
   logic              rsp_valid_ff;
   logic [IDX_W-1:0]  rsp_index_ff;
   logic              rsp_error_ff;

   logic [CNTW-1:0]   count_wide;
   logic [CNTW-1:0]   n_eff;
   logic [CNTW-1:0]   n_m1;
   logic [CNTW-1:0]   n_m2;
   logic              count_short;
   logic [AW-1:0]     pos_next;
   logic              scan_end;
   logic              rsp_free;
   cmp_result_type    cmp;

   // Effective bin count, saturated to the table depth.
   always_comb begin
      count_wide = CNTW'(freq_count);
      if (count_wide > CNTW'(MAX_BINS)) begin
         n_eff = CNTW'(MAX_BINS);
      end else begin
         n_eff = count_wide;
      end
      n_m1        = n_eff - CNTW'(1);
      n_m2        = n_eff - CNTW'(2);
      count_short = (n_eff < CNTW'(2));
   end

   assign pos_next = pos_ff + AW'(1);
   assign scan_end = (pos_next == last_ff);
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Shared distance and order compare.
   nbis_cmp_unit u_cmp (
      .center_freq (freq_ff),
      .entry       (rd_data),
      .best_diff   (best_ff),
      .prev_entry  (prev_ff),
      .result      (cmp)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (query_start) begin
               state_in = count_short ? S_DONE : S_TAIL0;
            end
         end
         S_TAIL0: begin
            state_in = S_TAIL1;
         end
         S_TAIL1: begin
            state_in = cmp.not_above ? S_DONE : S_HEAD0;
         end
         S_HEAD0: begin
            state_in = S_HEAD1;
         end
         S_HEAD1: begin
            if (cmp.not_above || !cmp.closer || scan_end) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!cmp.closer || scan_end) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Table read address and request ready for each state.
   always_comb begin
      idle    = 1'b0;
      rd_en   = 1'b1;
      rd_addr = '0;
      unique case (state_ff) inside
         S_IDLE: begin
            idle    = 1'b1;
            rd_addr = n_m2[AW-1:0];
         end
         S_TAIL0: begin
            rd_addr = last_ff;
         end
         S_TAIL1: begin
            rd_addr = '0;
         end
         S_HEAD0: begin
            rd_addr = AW'(1);
         end
         S_HEAD1, S_SCAN: begin
            rd_addr = pos_ff + AW'(2);
         end
         S_DONE: begin
            rd_en = 1'b0;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Scan datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (query_start) begin
               freq_ff <= query_freq;
               last_ff <= n_m1[AW-1:0];
               pos_ff  <= '0;
               err_ff  <= count_short ? ERR_ORDER : ERR_NONE;
            end
         end
         S_TAIL0: begin
            prev_ff <= rd_data;
         end
         S_TAIL1: begin
            if (cmp.not_above) begin
               err_ff <= ERR_ORDER;
            end
         end
         S_HEAD0: begin
            prev_ff <= rd_data;
            best_ff <= cmp.diff;
         end
         S_HEAD1: begin
            if (cmp.not_above) begin
               err_ff <= ERR_ORDER;
            end else if (cmp.closer) begin
               pos_ff  <= pos_next;
               best_ff <= cmp.diff;
            end
         end
         S_SCAN: begin
            if (cmp.closer) begin
               pos_ff  <= pos_next;
               best_ff <= cmp.diff;
            end
         end
         default: begin
         end
      endcase
   end

   // Response output register; it frees the sequencer while a response waits.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_DONE && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && rsp_free) begin
         rsp_index_ff <= (err_ff == ERR_ORDER) ? '0 : IDX_W'(pos_ff);
         rsp_error_ff <= err_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_center_index = rsp_index_ff;
   assign rsp_error        = rsp_error_ff;

endmodule

`default_nettype wire

// ===== hdl/nbis_checker.sv =====
// ----------------------------------------------------------------------------
// Nearest bin index search checker
// Port-level checks of response holding, error results and request timing.
// ----------------------------------------------------------------------------
`default_nettype none

module nbis_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic [nbis_pkg::OP_W-1:0]    req_op,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [nbis_pkg::IDX_W-1:0]   rsp_center_index,
   input wire logic                         rsp_error
);
   import nbis_pkg::*;

   // A stalled response holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_center_index)
                                  && $stable(rsp_error))
      else $error("stalled response changed");

   // An error response always reports bin zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error == ERR_ORDER) |-> rsp_center_index == '0)
      else $error("error response with nonzero index");

   // A query keeps the block busy for the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_QUERY) |=> !req_ready)
      else $error("ready right after a query");

   // The block is ready again in the cycle after a table write.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_WRITE) |=> req_ready)
      else $error("not ready after a table write");

   // No response is pending right after reset.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind nearest_bin_index_search nbis_checker u_nbis_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .req_op           (req.op),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_center_index (rsp.center_index),
   .rsp_error        (rsp.error)
);

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Nearest bin index search testbench
// Drives table writes and nearest-bin queries through the request channel and
// checks every response against a predictor of the scan. The predictor keeps
// its own bin table and bin count. The run goes through several bin counts,
// from the smallest and largest settings to counts that must saturate.
// ----------------------------------------------------------------------------

module tb_top;
   import nbis_pkg::*;

   localparam int TABLE_DEPTH   = 512;
   localparam int MAX_REPORTS   = 10;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 600;
   localparam logic [FREQ_W-1:0] FREQ_TOP = {FREQ_W{1'b1}};

   typedef struct packed {
      op_type            op;
      logic [IDX_W-1:0]  entry_index;
      logic [FREQ_W-1:0] frequency;
   } table_request_type;

   typedef struct packed {
      logic [IDX_W-1:0] center_index;
      logic             error;
   } bin_answer_type;

   // Clock, reset and the block inputs, all known from time zero.
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               send_valid = 1'b0;
   table_request_type  send_item = '0;
   logic               rsp_ready = 1'b0;
   logic               csr_write_enable = 1'b0;
   logic [COUNT_W-1:0] csr_write_data = '0;

   nbis_req_if req_ch ();
   nbis_rsp_if rsp_ch ();

   assign req_ch.valid       = send_valid;
   assign req_ch.op          = send_item.op;
   assign req_ch.entry_index = send_item.entry_index;
   assign req_ch.frequency   = send_item.frequency;
   assign rsp_ch.ready       = rsp_ready;

   nearest_bin_index_search uut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Transactions waiting to be sent and answers waiting to arrive.
   table_request_type pending_items[$];
   bin_answer_type    awaited_answers[$];

   // Predictor state: the bin table as the block should hold it.
   logic [FREQ_W-1:0]  bin_table [TABLE_DEPTH];
   logic [COUNT_W-1:0] bin_count = COUNT_RESET;

   // Table contents as planned by the stimulus, used to aim queries and to
   // keep queries away from entries that were never written.
   logic [FREQ_W-1:0] plan_table [TABLE_DEPTH];
   bit                plan_written [TABLE_DEPTH];

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned items_queued = 0;
   int unsigned writes_seen = 0;
   int unsigned answers_checked = 0;
   int unsigned order_errors = 0;
   int unsigned counts_set = 0;
   int unsigned mismatch_count = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   // Number of bins the scan really uses; larger counts saturate.
   function automatic int unsigned bins_in_use();
      return (bin_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(bin_count);
   endfunction

   function automatic logic [FREQ_W-1:0] freq_gap(logic [FREQ_W-1:0] a, logic [FREQ_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Expected answer to a query: check both table ends, then walk up from
   // bin 0 while the next bin is strictly closer to the center.
   function automatic bin_answer_type find_nearest_bin(logic [FREQ_W-1:0] center);
      int unsigned n;
      int unsigned pos;
      bin_answer_type answer;
      n = bins_in_use();
      answer.center_index = '0;
      answer.error = ERR_ORDER;
      if (n < 2 || bin_table[1] <= bin_table[0] || bin_table[n-1] <= bin_table[n-2])
         return answer;
      pos = 0;
      while (pos < n - 1 &&
             freq_gap(center, bin_table[pos]) > freq_gap(center, bin_table[pos+1]))
         pos++;
      answer.center_index = pos[IDX_W-1:0];
      answer.error = ERR_NONE;
      return answer;
   endfunction

   // Update the predictor with one accepted request.
   function automatic void apply_request(table_request_type item);
      if (item.op == OP_WRITE) begin
         bin_table[item.entry_index] = item.frequency;
         writes_seen++;
      end else begin
         awaited_answers.push_back(find_nearest_bin(item.frequency));
      end
   endfunction

   function automatic void queue_write(int unsigned idx, logic [FREQ_W-1:0] freq);
      table_request_type item;
      item.op = OP_WRITE;
      item.entry_index = idx[IDX_W-1:0];
      item.frequency = freq;
      pending_items.push_back(item);
      plan_table[idx[IDX_W-1:0]] = freq;
      plan_written[idx[IDX_W-1:0]] = 1'b1;
      items_queued++;
   endfunction

   // A query is only queued once every entry that the scan may touch has
   // been written. With a count below two the whole table must be written.
   function automatic void queue_query(logic [FREQ_W-1:0] center);
      table_request_type item;
      int unsigned span;
      span = (bin_count < 2) ? TABLE_DEPTH : bins_in_use();
      for (int unsigned i = 0; i < span; i++)
         if (!plan_written[i])
            return;
      item.op = OP_QUERY;
      item.entry_index = IDX_W'($urandom_range(TABLE_DEPTH - 1, 0));
      item.frequency = center;
      pending_items.push_back(item);
      items_queued++;
   endfunction

   // Write bins 0..n-1 with strictly ascending, evenly spread frequencies.
   function automatic void fill_ascending(int unsigned n);
      longint unsigned span;
      longint unsigned base;
      if ($urandom_range(1, 0) == 1)
         span = $urandom_range(FREQ_TOP, n - 1);
      else
         span = $urandom_range(n * 400, n - 1);
      base = $urandom_range(FREQ_TOP - FREQ_W'(span), 0);
      for (int unsigned i = 0; i < n; i++)
         queue_write(i, FREQ_W'(base + span * i / (n - 1)));
   endfunction

   // Query center aimed at the planned table: extremes, exact bins, points
   // near a bin and midpoints between neighbors, where ties happen.
   function automatic logic [FREQ_W-1:0] pick_center(int unsigned n);
      int unsigned k;
      longint v;
      k = $urandom_range(n - 2, 0);
      case ($urandom_range(7, 0)) inside
         0: v = $urandom_range(FREQ_TOP, 0);
         1: v = 0;
         2: v = FREQ_TOP;
         3: v = plan_table[k + $urandom_range(1, 0)];
         4, 5: v = longint'(plan_table[k]) + longint'($urandom_range(8, 0)) - 4;
         default: v = (longint'(plan_table[k]) + longint'(plan_table[k+1])) / 2;
      endcase
      if (v < 0)
         v = 0;
      if (v > longint'(FREQ_TOP))
         v = FREQ_TOP;
      return FREQ_W'(v);
   endfunction

   // One table session: a fresh ascending table, sometimes disturbed, then
   // a few queries and some stray traffic.
   function automatic void queue_session(int unsigned queries);
      int unsigned n;
      n = bins_in_use();
      fill_ascending(n);
      // A dip in the interior makes the scan stop on a local minimum.
      if (n > 3 && $urandom_range(4, 0) == 0)
         queue_write($urandom_range(n - 2, 1), FREQ_W'($urandom_range(FREQ_TOP, 0)));
      // Now and then one end of the table is no longer ascending.
      case ($urandom_range(9, 0))
         0: queue_write(1, FREQ_W'($urandom_range(plan_table[0], 0)));
         1: queue_write(n - 1, FREQ_W'($urandom_range(plan_table[n-2], 0)));
         default: ;
      endcase
      repeat (queries)
         queue_query(pick_center(n));
      repeat ($urandom_range(3, 0)) begin
         if ($urandom_range(1, 0) == 0)
            queue_write($urandom_range(TABLE_DEPTH - 1, 0), FREQ_W'($urandom));
         else
            queue_query(pick_center(n));
      end
   endfunction

   // Wait until nothing is left to send and every answer has arrived.
   task automatic drain_all();
      do
         @(negedge clock);
      while (pending_items.size() != 0 || send_valid || awaited_answers.size() != 0);
   endtask

   // The bin count is only changed while the block is idle.
   task automatic set_bin_count(logic [COUNT_W-1:0] value);
      drain_all();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      bin_count = value;
      counts_set++;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_stretch(int unsigned budget);
      int unsigned stop;
      stop = items_queued + budget;
      while (items_queued < stop) begin
         if ($urandom_range(3, 0) == 0)
            set_bin_count(COUNT_W'(2));
         else
            set_bin_count(COUNT_W'($urandom_range(24, 3)));
         repeat (3)
            queue_session($urandom_range(6, 2));
      end
   endtask

   // Request driver: offers the next pending transaction when the slot is
   // free and the sender is not idling, and feeds accepted ones to the
   // predictor.
   always @(posedge clock) begin : request_driver
      table_request_type next_item;
      if (reset) begin
         send_valid <= 1'b0;
      end else begin
         if (send_valid && req_ch.ready) begin
            apply_request(send_item);
         end
         if (!send_valid || req_ch.ready) begin
            if (pending_items.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               next_item = pending_items.pop_front();
               send_item <= next_item;
               send_valid <= 1'b1;
            end else begin
               send_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each accepted response against the oldest
   // awaited answer and stalls the block at random.
   always @(posedge clock) begin : response_monitor
      bin_answer_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ready) begin
            if (awaited_answers.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("Unexpected response: center_index %0d error %0d",
                           rsp_ch.center_index, rsp_ch.error);
            end else begin
               want = awaited_answers.pop_front();
               answers_checked++;
               if (want.error == ERR_ORDER)
                  order_errors++;
               if (rsp_ch.center_index !== want.center_index
                   || rsp_ch.error !== want.error) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display({"Response mismatch: expected center_index %0d error %0d,",
                               " got center_index %0d error %0d"},
                              want.center_index, want.error,
                              rsp_ch.center_index, rsp_ch.error);
               end
            end
         end
         rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // Stimulus sequence.
   initial begin
      send_idle_pct = 28;
      recv_idle_pct = 62;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Four bins holding both frequency extremes.
      set_bin_count(COUNT_W'(4));
      queue_write(0, '0);
      queue_write(1, 24'h000100);
      queue_write(2, 24'h000200);
      queue_write(3, FREQ_TOP);
      queue_write(TABLE_DEPTH - 1, FREQ_TOP);
      queue_query('0);
      queue_query(FREQ_TOP);
      // Centers exactly between two bins stay on the lower bin.
      queue_query(24'h000080);
      queue_query(24'h000180);
      queue_query(24'h000181);
      // A dip at bin 2 stops the scan at bin 1.
      queue_write(2, 24'h000050);
      queue_query(24'h000300);
      queue_write(2, 24'h000200);
      // Head of the table not ascending.
      queue_write(1, '0);
      queue_query(24'h000100);
      queue_write(1, 24'h000100);
      // Tail of the table not ascending.
      queue_write(3, 24'h000200);
      queue_query(24'h000100);
      queue_write(3, FREQ_TOP);
      queue_query(24'h7FFFFF);

      random_stretch(150);

      send_idle_pct = 62;
      recv_idle_pct = 28;
      random_stretch(280);

      send_idle_pct = 0;
      recv_idle_pct = 0;

      // Full table, then the largest and the saturating counts.
      fill_ascending(TABLE_DEPTH);
      set_bin_count(COUNT_W'(TABLE_DEPTH));
      repeat (6)
         queue_query(pick_center(TABLE_DEPTH));
      queue_write(TABLE_DEPTH - 1, plan_table[TABLE_DEPTH - 2]);
      queue_query(pick_center(TABLE_DEPTH));
      queue_write(TABLE_DEPTH - 1, FREQ_TOP);
      queue_query(pick_center(TABLE_DEPTH));
      set_bin_count({COUNT_W{1'b1}});
      repeat (4)
         queue_query(pick_center(TABLE_DEPTH));
      set_bin_count(COUNT_W'(700));
      repeat (3)
         queue_query(pick_center(TABLE_DEPTH));
      // Counts too small for a scan always report the order error.
      set_bin_count(COUNT_W'(0));
      repeat (2)
         queue_query(pick_center(TABLE_DEPTH));
      set_bin_count(COUNT_W'(1));
      repeat (2)
         queue_query(pick_center(TABLE_DEPTH));

      random_stretch(120);

      drain_all();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d table writes and %0d checked queries (%0d with the order error),",
               writes_seen, answers_checked, order_errors);
      $display("over %0d bin count settings from 0 to 1023 under three idling mixes.",
               counts_set);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Timeout guard, well above the slowest correct run.
   initial begin
      #10000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
